// ----- rtl/fmp_pkg.sv -----
// Shared widths and item types for the Fibonacci residue and Pisano period core.
package fmp_pkg;

  localparam int IDX_BITS = 63;
  localparam int MOD_BITS = 16;
  localparam int PER_BITS = MOD_BITS + 3;
  localparam int CNT_BITS = $clog2(IDX_BITS);

  typedef struct packed {
    logic [IDX_BITS-1:0] fib_index;
    logic [MOD_BITS-1:0] modulus;
  } req_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] fib_residue;
    logic [PER_BITS-1:0] period_length;
  } rsp_t;

endpackage

// ----- rtl/fmp_pair_step.sv -----
// Modular add that advances one Fibonacci pair: s = (a + b) mod m.
module fmp_pair_step (
  input  logic [fmp_pkg::MOD_BITS-1:0] a,
  input  logic [fmp_pkg::MOD_BITS-1:0] b,
  input  logic [fmp_pkg::MOD_BITS-1:0] m,
  output logic [fmp_pkg::MOD_BITS-1:0] s
);

  logic [fmp_pkg::MOD_BITS:0] sum;
  logic [fmp_pkg::MOD_BITS:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = sum - {1'b0, m};
  assign s    = (sum >= {1'b0, m}) ? diff[fmp_pkg::MOD_BITS-1:0]
                                   : sum[fmp_pkg::MOD_BITS-1:0];

endmodule

// ----- rtl/fmp_rem.sv -----
// Restoring bit-serial remainder of the index by the period, one bit per cycle.
module fmp_rem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fmp_pkg::IDX_BITS-1:0] dividend,
  input  logic [fmp_pkg::PER_BITS-1:0] divisor,
  output logic                         done,
  output logic [fmp_pkg::PER_BITS-1:0] rem
);

  logic                         busy;
  logic [fmp_pkg::CNT_BITS-1:0] cnt;
  logic [fmp_pkg::IDX_BITS-1:0] shreg;
  logic [fmp_pkg::PER_BITS-1:0] div;
  logic [fmp_pkg::PER_BITS:0]   trial;
  logic [fmp_pkg::PER_BITS:0]   trial_sub;

  assign trial     = {rem, shreg[fmp_pkg::IDX_BITS-1]};
  assign trial_sub = trial - {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      div   <= divisor;
      rem   <= '0;
      cnt   <= fmp_pkg::CNT_BITS'(fmp_pkg::IDX_BITS - 1);
    end else if (busy) begin
      shreg <= shreg << 1;
      cnt   <= cnt - 1'b1;
      if (trial >= {1'b0, div}) begin
        rem <= trial_sub[fmp_pkg::PER_BITS-1:0];
      end else begin
        rem <= trial[fmp_pkg::PER_BITS-1:0];
      end
    end
  end

endmodule

// ----- rtl/fibonacci_modulo_pisano_core.sv -----
// Top level of the Fibonacci residue and Pisano period core.
// Each item returns F(n) mod m and the Pisano period P of m. One modular adder
// steps the pair (F(i), F(i+1)) mod m: first until (0,1) returns, which gives
// P, then a bit-serial remainder yields n mod P from the 63 index bits, then
// the adder steps n mod P times from (0,1) to reach the element, and the
// result is loaded into the output register. P is at most 6m. A modulus of 0
// or 1 skips the search and the walk and gives residue 0 and period 1. The
// block takes one item at a time and holds req_stall high until its result is
// loaded into the output register.
module fibonacci_modulo_pisano_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  fmp_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output fmp_pkg::rsp_t  rsp
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PERIOD = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]                   state;
  logic [fmp_pkg::IDX_BITS-1:0] n;
  logic [fmp_pkg::MOD_BITS-1:0] m;
  logic [fmp_pkg::MOD_BITS-1:0] a;
  logic [fmp_pkg::MOD_BITS-1:0] b;
  logic [fmp_pkg::MOD_BITS-1:0] s;
  logic [fmp_pkg::PER_BITS-1:0] cnt;
  logic [fmp_pkg::PER_BITS-1:0] cnt_next;
  logic [fmp_pkg::PER_BITS-1:0] cap;
  logic [fmp_pkg::PER_BITS-1:0] per;
  logic [fmp_pkg::PER_BITS-1:0] k;
  logic [fmp_pkg::PER_BITS-1:0] m_wide;
  logic [fmp_pkg::PER_BITS-1:0] rem;
  logic                         hit;
  logic                         div_start;
  logic                         div_done;
  logic                         load;

  assign req_stall = (state != S_IDLE);
  assign cnt_next  = cnt + 1'b1;
  assign hit       = ((b == '0) && (s == fmp_pkg::MOD_BITS'(1))) || (cnt_next == cap);
  assign div_start = (state == S_PERIOD) && hit;
  assign m_wide    = fmp_pkg::PER_BITS'(req.modulus);
  assign load      = (state == S_FINISH) && (!rsp_valid || !rsp_stall);

  fmp_pair_step u_step (
    .a (a),
    .b (b),
    .m (m),
    .s (s)
  );

  fmp_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (cnt_next),
    .done     (div_done),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= (req.modulus <= fmp_pkg::MOD_BITS'(1)) ? S_FINISH : S_PERIOD;
          end
        end
        S_PERIOD: begin
          if (hit) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (k == '0) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          n   <= req.fib_index;
          m   <= req.modulus;
          a   <= '0;
          b   <= fmp_pkg::MOD_BITS'(1);
          cnt <= '0;
          per <= fmp_pkg::PER_BITS'(1);
          cap <= (m_wide << 2) + (m_wide << 1) + fmp_pkg::PER_BITS'(6);
        end
      end
      S_PERIOD: begin
        a   <= b;
        b   <= s;
        cnt <= cnt_next;
        if (hit) begin
          per <= cnt_next;
        end
      end
      S_DIV: begin
        if (div_done) begin
          k <= rem;
          a <= '0;
          b <= fmp_pkg::MOD_BITS'(1);
        end
      end
      S_WALK: begin
        if (k != '0) begin
          a <= b;
          b <= s;
          k <= k - 1'b1;
        end
      end
      S_FINISH: begin
        if (load) begin
          rsp.fib_residue   <= a;
          rsp.period_length <= per;
        end
      end
      default: begin
      end
    endcase
  end

  a_pair_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PERIOD || state == S_WALK) |-> (a < m) && (b < m))
    else $error("pair element not reduced by modulus");

  a_walk_below_period: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (k < per))
    else $error("walk count not below period");

  a_period_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.period_length != '0))
    else $error("zero period delivered");

  a_period_needs_modulus: assert property (@(posedge clk) disable iff (rst)
    (state == S_PERIOD) |-> (m > fmp_pkg::MOD_BITS'(1)))
    else $error("period search with trivial modulus");

endmodule

// ----- tb/fmp_result_checker.sv -----
// Checker that predicts and compares residue and period items of the Fibonacci core.
module fmp_result_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  fmp_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  fmp_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  fmp_pkg::rsp_t due_results[$];
  fmp_pkg::rsp_t want;
  int            mismatch_count = 0;

  assign fail_count = mismatch_count;

  function automatic logic [fmp_pkg::PER_BITS-1:0] pisano_length(
      input logic [fmp_pkg::MOD_BITS-1:0] m);
    logic [fmp_pkg::MOD_BITS:0] a;
    logic [fmp_pkg::MOD_BITS:0] b;
    logic [fmp_pkg::MOD_BITS:0] s;
    logic [31:0]                steps;
    logic [31:0]                cap;
    if (m <= 1) return fmp_pkg::PER_BITS'(1);
    a = 0;
    b = 1;
    steps = 0;
    cap = 6 * m + 6;
    do begin
      s = a + b;
      if (s >= m) s = s - m;
      a = b;
      b = s;
      steps++;
    end while (!(a == 0 && b == 1) && steps < cap);
    return steps[fmp_pkg::PER_BITS-1:0];
  endfunction

  function automatic logic [fmp_pkg::MOD_BITS-1:0] residue_at(
      input logic [fmp_pkg::IDX_BITS-1:0] n,
      input logic [fmp_pkg::MOD_BITS-1:0] m,
      input logic [fmp_pkg::PER_BITS-1:0] period);
    logic [63:0]                k;
    logic [fmp_pkg::MOD_BITS:0] a;
    logic [fmp_pkg::MOD_BITS:0] b;
    logic [fmp_pkg::MOD_BITS:0] s;
    if (m <= 1) return '0;
    k = {1'b0, n} % {{(64-fmp_pkg::PER_BITS){1'b0}}, period};
    a = 0;
    b = 1;
    for (logic [63:0] i = 0; i < k; i++) begin
      s = a + b;
      if (s >= m) s = s - m;
      a = b;
      b = s;
    end
    return a[fmp_pkg::MOD_BITS-1:0];
  endfunction

  function automatic fmp_pkg::rsp_t fib_mod_result(input fmp_pkg::req_t item);
    fmp_pkg::rsp_t r;
    r.period_length = pisano_length(item.modulus);
    r.fib_residue   = residue_at(item.fib_index, item.modulus, r.period_length);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pending <= 0;
    end else begin
      if (req_valid && !req_stall) due_results = {due_results, fib_mod_result(req)};
      if (rsp_valid && !rsp_stall) begin
        if (due_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected item residue=%0d period=%0d",
                     $realtime, rsp.fib_residue, rsp.period_length);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          if (rsp.fib_residue !== want.fib_residue ||
              rsp.period_length !== want.period_length) begin
            if (mismatch_count < 10)
              $display("%0t: mismatch residue exp=%0d got=%0d period exp=%0d got=%0d",
                       $realtime, want.fib_residue, rsp.fib_residue,
                       want.period_length, rsp.period_length);
            mismatch_count++;
          end
        end
      end
      pending <= due_results.size();
    end
  end

endmodule

// ----- tb/tb_fibonacci_modulo_pisano_core.sv -----
// Stimulus and verdict for the Fibonacci residue and Pisano period core.
module tb_fibonacci_modulo_pisano_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  fmp_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  fmp_pkg::rsp_t rsp;
  int            mismatch_total;
  int            pending;
  bit            quiet     = 1'b0;

  localparam logic [fmp_pkg::IDX_BITS-1:0] IDX_MAX = {fmp_pkg::IDX_BITS{1'b1}};

  always #10 clk = ~clk;

  fibonacci_modulo_pisano_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  fmp_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (mismatch_total),
    .pending    (pending)
  );

  task automatic offer(input logic [fmp_pkg::IDX_BITS-1:0] n,
                       input logic [fmp_pkg::MOD_BITS-1:0] m);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid       <= 1'b1;
    req.fib_index   <= n;
    req.modulus     <= m;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  initial begin
    logic [fmp_pkg::IDX_BITS-1:0] n;
    logic [fmp_pkg::MOD_BITS-1:0] m;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    offer(0, 0);
    offer(IDX_MAX, 0);
    offer(12345, 1);
    offer(IDX_MAX, 1);
    offer(0, 2);
    offer(1, 2);
    offer(IDX_MAX, 2);
    offer(2, 10);
    offer(0, 65535);
    offer(1, 65535);
    offer(IDX_MAX, 65535);
    offer(IDX_MAX, 50000);
    offer(1, 1000);
    offer(100, 1000);
    offer(IDX_MAX, 7);
    offer(60, 5);
    offer(fmp_pkg::IDX_BITS'({$urandom, $urandom}), 255);

    for (int i = 0; i < 100; i++) begin
      if (i % 16 == 0) quiet = 1'($urandom_range(0, 1));
      if (i == 60) begin
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      n = ($urandom_range(0, 3) == 0) ? fmp_pkg::IDX_BITS'($urandom_range(0, 20))
                                      : fmp_pkg::IDX_BITS'({$urandom, $urandom});
      if (i % 16 == 0)
        m = fmp_pkg::MOD_BITS'($urandom_range(256, 4095));
      else if ($urandom_range(0, 9) == 0)
        m = fmp_pkg::MOD_BITS'($urandom_range(0, 3));
      else
        m = fmp_pkg::MOD_BITS'($urandom_range(2, 255));
      offer(n, m);
    end

    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
    if (mismatch_total == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    int gap;
    int taken;
    taken = 0;
    @(negedge rst);
    forever begin
      gap = (taken == 20) ? 400 : $urandom_range(0, 8);
      if (gap > 0) begin
        rsp_stall <= 1'b1;
        @(posedge clk);
        while (!rsp_valid) @(posedge clk);
        repeat (gap - 1) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    #500ms;
    $display("tb: failure");
    $finish;
  end

endmodule
